FILE: hdl/ascc_pkg.sv
// ----------------------------------------------------------------------------
// ascc_pkg
// Shared types and codes of the armed sample capture controller.
// ----------------------------------------------------------------------------
package ascc_pkg;

	localparam int IN_DATA_W  = 112;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 104;
	localparam int OUT_USER_W = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam int EVQ_DEPTH = 4;
	localparam int EVQ_CW    = $clog2(EVQ_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_CAPACITY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 1'b1;

	typedef enum logic [3:0] {
		OP_FRAME   = 4'd0,
		OP_ARM     = 4'd1,
		OP_START   = 4'd2,
		OP_STOP    = 4'd3,
		OP_CANCEL  = 4'd4,
		OP_RESET   = 4'd5,
		OP_JUMP    = 4'd6,
		OP_READ    = 4'd7,
		OP_CONSUME = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		MODE_IDLE      = 3'd0,
		MODE_ARMED     = 3'd1,
		MODE_RECORDING = 3'd2,
		MODE_COMPLETED = 3'd3,
		MODE_CANCELLED = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		EV_ACCEPTED  = 3'd0,
		EV_REJECTED  = 3'd1,
		EV_STARTED   = 3'd2,
		EV_COMPLETED = 3'd3,
		EV_CANCELLED = 3'd4,
		EV_READ      = 3'd5
	} kind_t;

	typedef struct packed {
		kind_t        kind;
		logic [31:0]  tag;
		mode_t        mode;
		logic [12:0]  frames;
		logic [23:0]  value;
		logic [31:0]  total;
	} event_t;

endpackage

FILE: hdl/ascc_ram.sv
// ----------------------------------------------------------------------------
// ascc_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ascc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/ascc_evq.sv
// ----------------------------------------------------------------------------
// ascc_evq
// Small event queue between the capture pipeline and the result stream.
// ----------------------------------------------------------------------------
module ascc_evq import ascc_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  event_t                       push_data,
	output logic                         valid,
	input  logic                         ready,
	output event_t                       data,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = $clog2(DEPTH);

	event_t                     mem_q [DEPTH];
	logic [PW-1:0]              wr_ptr_q;
	logic [PW-1:0]              rd_ptr_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;
	logic                       pop;

	assign valid = (cnt_q != '0);
	assign data  = mem_q[rd_ptr_q];
	assign count = cnt_q;
	assign pop   = valid && ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: hdl/armed_sample_capture_controller.sv
// ----------------------------------------------------------------------------
// armed_sample_capture_controller
// Sample-accurate capture controller: frames and take commands in, events out.
// ----------------------------------------------------------------------------
// One request (a sample frame or a command) is taken per clock cycle while
// s_tready is high. All take state sits in registers and is updated in the
// cycle a request is accepted, so requests follow each other back to back;
// the sample store is one RAM per channel (FRAME_DEPTH words each, registered
// read). An event reaches the result stream through the stage-1 register
// (store read) and the four-entry event queue, which lets requests keep flowing
// while results wait; s_tready drops when it lacks room. After reset the store
// is swept to zero, one frame per cycle; s_tready stays low during the sweep
// (configuration writes are taken throughout). cfg_ready is always high.
// ----------------------------------------------------------------------------
module armed_sample_capture_controller import ascc_pkg::*; #(
	parameter int FRAME_DEPTH = 4096,
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// sample_ch0[23:0], sample_ch1[47:24], source_channels[49:48],
	// cmd_tag[81:50], request_frames[94:82], cancel_on_jump[95],
	// read_channel[96], read_frame[108:97], zero fill[111:109]
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// operation[3:0]
	input  logic [IN_USER_W-1:0]  s_tuser,
	// event stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// event_tag[31:0], mode_after[34:32], frames_done[47:35],
	// read_value[71:48], total_frames[103:72]
	output logic [OUT_DATA_W-1:0] m_tdata,
	// event_kind[2:0]
	output logic [OUT_USER_W-1:0] m_tuser,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(FRAME_DEPTH + 1);
	localparam int CW    = (CNT_W > 13) ? CNT_W : 13;
	localparam int AW    = $clog2(FRAME_DEPTH);
	localparam logic [CW-1:0] MAX_C   = CW'(FRAME_DEPTH);
	localparam logic [CW-1:0] CAP_RST = CW'((FRAME_DEPTH < 4096) ? FRAME_DEPTH : 4096);

	// ---------------------------------------------------------------- fields
	op_t                 op;
	logic signed [23:0]  in_samp [2];
	logic [1:0]          src_ch;
	logic [31:0]         seq_id;
	logic [12:0]         req_frames;
	logic                jump_flag;
	logic                rd_ch;
	logic [11:0]         rd_frame;

	assign op         = op_t'(s_tuser);
	assign in_samp[0] = s_tdata[23:0];
	assign in_samp[1] = s_tdata[47:24];
	assign src_ch     = s_tdata[49:48];
	assign seq_id     = s_tdata[81:50];
	assign req_frames = s_tdata[94:82];
	assign jump_flag  = s_tdata[95];
	assign rd_ch      = s_tdata[96];
	assign rd_frame   = s_tdata[108:97];

	// ---------------------------------------------------------------- config
	logic [12:0] fcap_q;
	logic [1:0]  chan_cnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcap_q     <= 13'd4096;
			chan_cnt_q <= 2'd2;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_CAPACITY: fcap_q     <= cfg_data;
				REG_CHANNEL_COUNT:  chan_cnt_q <= cfg_data[1:0];
				default:            ;
			endcase
		end
	end

	// effective capacity and channel use
	logic [CW-1:0] cap;
	logic [CW-1:0] fcap_ext;
	logic          ch1_on;

	assign fcap_ext = CW'(fcap_q);
	assign ch1_on   = (CHANNELS > 1) && (chan_cnt_q >= 2'd2);

	always_comb begin
		if (fcap_q == '0) begin
			cap = CW'(1);
		end else if (fcap_ext > MAX_C) begin
			cap = MAX_C;
		end else begin
			cap = fcap_ext;
		end
	end

	// ---------------------------------------------------------------- take state
	mode_t         mode_q, mode_d;
	logic [CW-1:0] rc_q, rc_d;
	logic [CW-1:0] target_q, target_d;
	logic          jump_q, jump_d;
	logic [31:0]   active_q, active_d;
	logic [31:0]   life_q, life_d;

	logic          acc;
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	assign acc = s_tvalid && s_tready;

	logic          st_idle, st_armed, st_rec, st_done, st_canc;
	logic [CW-1:0] req_ext;
	logic [CW-1:0] rc_inc;
	logic          req_big;
	logic          frm_full;    // target met or store end reached before this frame
	logic          frm_wr;      // this frame writes the store
	logic          frm_fin;     // this frame completes the take
	logic          can_arm, can_start;
	logic [31:0]   tag_sel;     // request tag, active tag when zero

	assign st_idle   = (mode_q == MODE_IDLE);
	assign st_armed  = (mode_q == MODE_ARMED);
	assign st_rec    = (mode_q == MODE_RECORDING);
	assign st_done   = (mode_q == MODE_COMPLETED);
	assign st_canc   = (mode_q == MODE_CANCELLED);
	assign req_ext   = CW'(req_frames);
	assign rc_inc    = rc_q + 1'b1;
	assign req_big   = (req_ext > cap);
	assign frm_full  = (rc_q >= target_q) || (rc_q >= MAX_C);
	assign frm_wr    = (op == OP_FRAME) && st_rec && !frm_full;
	assign frm_fin   = st_rec && (frm_full || (rc_inc >= target_q));
	assign can_arm   = !req_big && (st_idle || st_canc);
	assign can_start = !req_big && (st_idle || st_armed || st_canc);
	assign tag_sel   = (seq_id == '0) ? active_q : seq_id;

	// next mode
	always_comb begin
		mode_d = mode_q;
		case (op)
			OP_FRAME:   if (frm_fin) mode_d = MODE_COMPLETED;
			OP_ARM:     if (can_arm) mode_d = MODE_ARMED;
			OP_START:   if (can_start) mode_d = MODE_RECORDING;
			OP_STOP:    if (st_rec) mode_d = MODE_COMPLETED;
			OP_CANCEL:  if (st_rec || st_armed) mode_d = MODE_CANCELLED;
			OP_RESET:   mode_d = MODE_IDLE;
			OP_JUMP:    if (jump_q && (st_armed || st_rec)) mode_d = MODE_CANCELLED;
			OP_CONSUME: if (st_done) mode_d = MODE_IDLE;
			default:    mode_d = mode_q;
		endcase
	end

	// register updates and the event of this request
	logic  ev_valid;
	kind_t ev_kind;
	logic [31:0] ev_tag;

	always_comb begin
		rc_d     = rc_q;
		target_d = target_q;
		jump_d   = jump_q;
		active_d = active_q;
		life_d   = life_q;
		ev_valid = 1'b0;
		ev_kind  = EV_ACCEPTED;
		ev_tag   = seq_id;
		case (op)
			OP_FRAME: begin
				if (frm_wr) begin
					rc_d = rc_inc;
					if (life_q != '1) begin
						life_d = life_q + 1'b1;
					end
				end
				if (frm_fin) begin
					ev_valid = 1'b1;
					ev_kind  = EV_COMPLETED;
					ev_tag   = active_q;
					active_d = '0;
				end
			end
			OP_ARM: begin
				ev_valid = 1'b1;
				if (can_arm) begin
					target_d = (req_frames == '0) ? cap : req_ext;
					jump_d   = jump_flag;
					active_d = seq_id;
				end else begin
					ev_kind = EV_REJECTED;
				end
			end
			OP_START: begin
				ev_valid = 1'b1;
				if (can_start) begin
					ev_kind  = EV_STARTED;
					rc_d     = '0;
					active_d = seq_id;
					// a plain start from armed keeps the armed length and jump flag
					if (!(st_armed && (req_frames == '0))) begin
						target_d = (req_frames == '0) ? cap : req_ext;
						jump_d   = jump_flag;
					end
				end else begin
					ev_kind = EV_REJECTED;
				end
			end
			OP_STOP: begin
				ev_valid = 1'b1;
				if (st_rec) begin
					ev_kind  = EV_COMPLETED;
					ev_tag   = tag_sel;
					active_d = '0;
				end else begin
					ev_kind = EV_REJECTED;
				end
			end
			OP_CANCEL: begin
				ev_valid = 1'b1;
				if (st_rec || st_armed) begin
					ev_kind  = EV_CANCELLED;
					ev_tag   = tag_sel;
					active_d = '0;
				end else begin
					ev_kind = EV_REJECTED;
				end
			end
			OP_RESET: begin
				ev_valid = 1'b1;
				rc_d     = '0;
				active_d = '0;
				target_d = cap;
				jump_d   = 1'b1;
			end
			OP_JUMP: begin
				if (jump_q && (st_armed || st_rec)) begin
					ev_valid = 1'b1;
					ev_kind  = EV_CANCELLED;
					ev_tag   = active_q;
					active_d = '0;
				end
			end
			OP_READ: begin
				ev_valid = 1'b1;
				ev_kind  = EV_READ;
			end
			OP_CONSUME: begin
				ev_valid = 1'b1;
				if (st_done) begin
					rc_d = '0;
				end else begin
					ev_kind = EV_REJECTED;
				end
			end
			default: ev_valid = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			rc_q     <= '0;
			target_q <= CAP_RST;
			jump_q   <= 1'b1;
			active_q <= '0;
			life_q   <= '0;
		end else if (acc) begin
			mode_q   <= mode_d;
			rc_q     <= rc_d;
			target_q <= target_d;
			jump_q   <= jump_d;
			active_q <= active_d;
			life_q   <= life_d;
		end
	end

	// ---------------------------------------------------------------- store clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == AW'(FRAME_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- sample store
	logic [CW-1:0]          rd_frame_ext;
	logic                   rd_ok;
	logic [SAMPLE_BITS-1:0] rdata [CHANNELS];

	assign rd_frame_ext = CW'(rd_frame);
	assign rd_ok        = ((rd_ch == 1'b0) || ch1_on) && (rd_frame_ext < cap);

	for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
		logic signed [31:0]     samp_ext;
		logic [SAMPLE_BITS-1:0] word;
		logic                   we;

		// absent source channels are written as zero
		assign samp_ext = 32'(in_samp[c]);
		assign word     = (src_ch > 2'(c)) ? samp_ext[SAMPLE_BITS-1:0] : '0;
		assign we       = clr_busy_q || (acc && frm_wr && ((c == 0) || ch1_on));

		ascc_ram #(
			.WIDTH (SAMPLE_BITS),
			.DEPTH (FRAME_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (we),
			.waddr (clr_busy_q ? clr_addr_q : rc_q[AW-1:0]),
			.wdata (clr_busy_q ? '0 : word),
			.re    (acc && (op == OP_READ)),
			.raddr (rd_frame_ext[AW-1:0]),
			.rdata (rdata[c])
		);
	end

	// ---------------------------------------------------------------- stage 1: read return
	logic   s1_valid_q;
	event_t s1_ev_s1;
	logic   s1_rd_ok_s1;
	logic   s1_rd_ch_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= acc && ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && ev_valid) begin
			s1_ev_s1.kind   <= ev_kind;
			s1_ev_s1.tag    <= ev_tag;
			s1_ev_s1.mode   <= mode_d;
			s1_ev_s1.frames <= rc_d[12:0];
			s1_ev_s1.value  <= '0;
			s1_ev_s1.total  <= life_d;
			s1_rd_ok_s1     <= (op == OP_READ) && rd_ok;
			s1_rd_ch_s1     <= rd_ch;
		end
	end

	logic [SAMPLE_BITS-1:0] rd_word;
	logic signed [31:0]     rd_ext;
	event_t                 push_ev;

	assign rd_word = ((CHANNELS > 1) && s1_rd_ch_s1) ? rdata[CHANNELS-1] : rdata[0];
	assign rd_ext  = 32'($signed(rd_word));

	always_comb begin
		push_ev = s1_ev_s1;
		if (s1_rd_ok_s1) begin
			push_ev.value = rd_ext[23:0];
		end
	end

	// ---------------------------------------------------------------- event queue
	event_t            out_ev;
	logic [EVQ_CW-1:0] q_cnt;

	ascc_evq #(
		.DEPTH (EVQ_DEPTH)
	) u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s1_valid_q),
		.push_data (push_ev),
		.valid     (m_tvalid),
		.ready     (m_tready),
		.data      (out_ev),
		.count     (q_cnt)
	);

	// room for everything in flight plus this request
	assign s_tready = !clr_busy_q &&
		((EVQ_CW + 1)'(q_cnt) + (EVQ_CW + 1)'(s1_valid_q) < (EVQ_CW + 1)'(EVQ_DEPTH));

	assign m_tdata = {out_ev.total, out_ev.value, out_ev.frames, out_ev.mode, out_ev.tag};
	assign m_tuser = out_ev.kind;

endmodule

FILE: hdl/ascc_checker.sv
// ----------------------------------------------------------------------------
// ascc_checker
// Port-level checks of the capture controller, bound to the top level.
// ----------------------------------------------------------------------------
module ascc_checker import ascc_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic [IN_USER_W-1:0]  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// stalled event holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("event changed while stalled");

	// only read events carry sample data
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != EV_READ) |-> (m_tdata[71:48] == '0))
		else $error("read_value set on non-read event");

	// a started take is recording from frame zero
	a_started: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == EV_STARTED) |->
			(m_tdata[34:32] == MODE_RECORDING) && (m_tdata[47:35] == '0))
		else $error("started event with wrong mode or count");

	a_completed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == EV_COMPLETED) |-> (m_tdata[34:32] == MODE_COMPLETED))
		else $error("completed event without completed mode");

	a_cancelled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == EV_CANCELLED) |-> (m_tdata[34:32] == MODE_CANCELLED))
		else $error("cancelled event without cancelled mode");

endmodule

bind armed_sample_capture_controller ascc_checker u_ascc_checker (.*);
